@@ rtl/core/kss_pkg.sv @@
package kss_pkg;

    // field widths of one query word and one result word
    localparam int N_W   = 6;
    localparam int K_W   = 5;
    localparam int SUM_W = 10;
    localparam int CNT_W = 30;

    // defaults for the top-level parameters
    localparam int DEF_MAX_N = 32;
    localparam int DEF_MAX_K = 16;

    // counts saturate at all ones
    localparam logic [CNT_W-1:0] COUNT_LIMIT = '1;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture query fields
        logic clr_wr;     // clearing sweep: write one table cell
        logic cell_wr;    // table update: write back one cell
        logic fetch_sel;  // point read port A at the answer cell
        logic out_load;   // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic zero;       // answer known to be zero, no search needed
        logic run_empty;  // no table cells to update
        logic clr_last;   // last cell of the clearing sweep
        logic cell_last;  // last cell of the table update
    } t_sts;

endpackage

@@ rtl/core/k_subset_sum_counter.sv @@
// A clearing sweep writes all (k+1)*(s+1) table cells; then each table cell is read and
// written back (one read, one write-back on a shared dual-read memory), then the answer
// cell is read and the result loaded. Cells number sum over x=1..min(n,s) of
// min(x,k)*(s-x+1). Zero-answer queries (k above n or above MAX_K) skip the table.
// One query in flight; the next word is taken once the result is loaded.
// Reset (synchronous, active low) clears the sequencer and output valid only.
module k_subset_sum_counter #(
    parameter int MAX_N = kss_pkg::DEF_MAX_N,
    parameter int MAX_K = kss_pkg::DEF_MAX_K
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [kss_pkg::N_W-1:0]     i_set_size,
    input  logic [kss_pkg::K_W-1:0]     i_pick_count,
    input  logic [kss_pkg::SUM_W-1:0]   i_target_sum,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [kss_pkg::CNT_W-1:0]   o_subset_count
);
    import kss_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer
    kss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // table, counters and result register
    kss_datapath #(
        .MAX_N (MAX_N),
        .MAX_K (MAX_K)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_set_size     (i_set_size),
        .i_pick_count   (i_pick_count),
        .i_target_sum   (i_target_sum),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_subset_count (o_subset_count)
    );

endmodule

@@ rtl/core/kss_datapath.sv @@
module kss_datapath #(
    parameter int MAX_N = kss_pkg::DEF_MAX_N,
    parameter int MAX_K = kss_pkg::DEF_MAX_K
) (
    input  logic                        i_clk,
    input  logic [kss_pkg::N_W-1:0]     i_set_size,
    input  logic [kss_pkg::K_W-1:0]     i_pick_count,
    input  logic [kss_pkg::SUM_W-1:0]   i_target_sum,
    input  kss_pkg::t_cmd               i_cmd,
    output kss_pkg::t_sts               o_sts,
    output logic [kss_pkg::CNT_W-1:0]   o_subset_count
);
    import kss_pkg::*;

    localparam int KW    = $clog2(MAX_K + 1);
    localparam int XW    = $clog2(MAX_N + 1);
    localparam int AW    = KW + SUM_W;
    localparam int DEPTH = 2 ** AW;

    // query registers and loop counters
    logic [XW-1:0]    r_n;
    logic [XW-1:0]    r_x;
    logic [KW-1:0]    r_k;
    logic [KW-1:0]    r_j;
    logic [SUM_W-1:0] r_s;
    logic [SUM_W-1:0] r_t;
    logic             r_zero;

    // ways table: row j holds counts of j-subsets by sum
    logic [CNT_W-1:0] r_mem [0:DEPTH-1];
    logic [CNT_W-1:0] r_rd_a;
    logic [CNT_W-1:0] r_rd_b;
    logic [CNT_W-1:0] r_count;

    logic [7:0]       w_n_ext;
    logic [7:0]       w_n_sat;
    logic [7:0]       w_k_ext;
    logic             w_zero_in;
    logic             w_t_more;
    logic             w_j_more;
    logic             w_x_more;
    logic [XW-1:0]    w_x1;
    logic [KW-1:0]    w_j_top;
    logic [AW-1:0]    w_addr_a;
    logic [AW-1:0]    w_addr_b;
    logic [AW-1:0]    w_addr_w;
    logic [CNT_W:0]   w_sum;
    logic [CNT_W-1:0] w_wdata;
    logic             w_we;

    // query decode: saturate n, spot the trivially zero cases
    always_comb begin
        w_n_ext   = {2'b00, i_set_size};
        w_n_sat   = (w_n_ext > 8'(MAX_N)) ? 8'(MAX_N) : w_n_ext;
        w_k_ext   = {3'b000, i_pick_count};
        w_zero_in = (w_k_ext > 8'(MAX_K)) || (w_k_ext > w_n_sat);
    end

    // loop position tests
    always_comb begin
        w_t_more = r_t > SUM_W'(r_x);
        w_j_more = r_j > KW'(1);
        w_x1     = r_x + XW'(1);
        w_x_more = (r_x < r_n) && ((11'(r_x) + 11'd1) <= 11'(r_s));
        w_j_top  = (8'(w_x1) < 8'(r_k)) ? KW'(w_x1) : r_k;
    end

    assign o_sts.zero      = r_zero;
    assign o_sts.run_empty = (r_n == '0) || (r_k == '0) || (r_s == '0);
    assign o_sts.clr_last  = (r_j == r_k) && (r_t == r_s);
    assign o_sts.cell_last = !w_t_more && !w_j_more && !w_x_more;

    // table addresses: A is ways[j][t] or the answer, B is ways[j-1][t-x]
    always_comb begin
        w_addr_w = {r_j, r_t};
        w_addr_a = i_cmd.fetch_sel ? {r_k, r_s} : {r_j, r_t};
        w_addr_b = {KW'(r_j - KW'(1)), SUM_W'(r_t - SUM_W'(r_x))};
    end

    // saturating add and write data
    always_comb begin
        w_sum = {1'b0, r_rd_a} + {1'b0, r_rd_b};
        w_we  = i_cmd.clr_wr || i_cmd.cell_wr;
        if (i_cmd.clr_wr) begin
            w_wdata = ((r_j == '0) && (r_t == '0)) ? CNT_W'(1) : '0;
        end else begin
            w_wdata = w_sum[CNT_W] ? COUNT_LIMIT : w_sum[CNT_W-1:0];
        end
    end

    // table memory, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr_w] <= w_wdata;
        end
        r_rd_a <= r_mem[w_addr_a];
        r_rd_b <= r_mem[w_addr_b];
    end

    // counters: clearing sweep then x / j / t update loop
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_n    <= XW'(w_n_sat);
            r_k    <= KW'(i_pick_count);
            r_s    <= i_target_sum;
            r_zero <= w_zero_in;
            r_j    <= '0;
            r_t    <= '0;
        end else if (i_cmd.clr_wr) begin
            if (o_sts.clr_last) begin
                r_x <= XW'(1);
                r_j <= KW'(1);
                r_t <= r_s;
            end else if (r_t == r_s) begin
                r_t <= '0;
                r_j <= r_j + KW'(1);
            end else begin
                r_t <= r_t + SUM_W'(1);
            end
        end else if (i_cmd.cell_wr) begin
            if (w_t_more) begin
                r_t <= r_t - SUM_W'(1);
            end else if (w_j_more) begin
                r_j <= r_j - KW'(1);
                r_t <= r_s;
            end else if (w_x_more) begin
                r_x <= w_x1;
                r_j <= w_j_top;
                r_t <= r_s;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_count <= r_zero ? '0 : r_rd_a;
        end
    end

    assign o_subset_count = r_count;

endmodule

@@ rtl/core/kss_ctrl.sv @@
module kss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  kss_pkg::t_sts i_sts,
    output kss_pkg::t_cmd o_cmd
);
    import kss_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_CLR   = 7'b0000100,
        S_RD    = 7'b0001000,
        S_WR    = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_RES   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // sequencer
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                n_state = i_sts.zero ? S_RES : S_CLR;
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = i_sts.run_empty ? S_FETCH : S_RD;
                end
            end
            S_RD: begin
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.cell_wr = 1'b1;
                n_state       = i_sts.cell_last ? S_FETCH : S_RD;
            end
            S_FETCH: begin
                o_cmd.fetch_sel = 1'b1;
                n_state         = S_RES;
            end
            S_RES: begin
                o_cmd.fetch_sel = 1'b1;
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // an accepted word always starts a query
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_START))
        else $error("accepted word did not start a query");

    // a loaded result is offered next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> r_out_valid)
        else $error("result loaded but not offered");

    // the last table cell leads straight to the answer read
    a_last_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.cell_wr && i_sts.cell_last) |=> (r_state == S_FETCH))
        else $error("update loop did not end in answer read");

    // trivially zero queries never write the table
    a_zero_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR || r_state == S_WR) |-> !i_sts.zero)
        else $error("table work on a zero query");

endmodule
